/* rtl/core/mclp_pkg.sv */
// ----------------------------------------------------------------------------
// mclp_pkg
// Request kinds and fixed field widths shared by the LED PWM block.
// ----------------------------------------------------------------------------
package mclp_pkg;

  localparam int unsigned KindW    = 2;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned PatternW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [KindW-1:0] {
    KindTick = 2'd0,
    KindSet  = 2'd1,
    KindSync = 2'd2
  } kind_e;

  typedef logic [LevelW-1:0]   level_t;
  typedef logic [PatternW-1:0] pattern_t;

endpackage

/* rtl/core/multi_channel_led_pwm.sv */
// ----------------------------------------------------------------------------
// multi_channel_led_pwm
// Multi-channel LED PWM with staged and active off-time levels.
// ----------------------------------------------------------------------------
// Each request passes an input register and a result register, so a request is
// accepted every cycle unless a result not yet taken stalls it; its result is
// presented on the master side from the result register and held there
// until taken. Set requests write a staged level to one LED or to all LEDs;
// a sync request arms a copy of the staged levels into the active levels at
// the next frame boundary. A tick request compares every active level with
// the step counter in parallel and returns the lit pattern; the frame runs
// through steps 0 to STEPS-2, and frame_start marks step 0. Level 0 is always
// on, level STEPS-1 and above always off. Every request gives exactly one
// result; set and sync return an all-dark pattern.
// ----------------------------------------------------------------------------
module multi_channel_led_pwm #(
  parameter int unsigned LED_COUNT = 16,
  parameter int unsigned STEPS     = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // led_index [3:0], broadcast [4], level [12:5], zero [15:13]
  input  logic [mclp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // kind [1:0]
  input  logic [mclp_pkg::KindW-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // led_pattern [15:0]
  output logic [mclp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // frame_start [0]
  output logic                           m_axis_tuser_o
);
  import mclp_pkg::*;

  localparam int unsigned StepW    = LevelW;
  localparam int unsigned PatLeds  = (LED_COUNT < PatternW) ? LED_COUNT : PatternW;
  localparam logic [StepW-1:0] OffLevel = StepW'(STEPS - 1);

  logic                 s1_valid_q;
  logic [KindW-1:0]     s1_kind_q;
  logic [IndexW-1:0]    s1_index_q;
  logic                 s1_all_q;
  level_t               s1_level_q;
  logic                 s1_adv;
  logic                 in_acc;

  level_t               staged_q [LED_COUNT];
  level_t               active_q [LED_COUNT];
  level_t               eff_level [LED_COUNT];
  logic [StepW-1:0]     step_q;
  logic [StepW-1:0]     step_d;
  logic [StepW:0]       step_inc;
  logic                 pend_q;

  logic                 is_tick;
  logic                 is_set;
  logic                 is_sync;
  logic                 at_frame;
  logic                 commit;
  pattern_t             pattern_d;

  logic                 out_valid_q;
  pattern_t             out_pattern_q;
  logic                 out_fstart_q;

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q  <= s_axis_tuser_i;
      s1_index_q <= s_axis_tdata_i[IndexW-1:0];
      s1_all_q   <= s_axis_tdata_i[IndexW];
      s1_level_q <= s_axis_tdata_i[IndexW+1 +: LevelW];
    end
  end

  always_comb begin
    is_tick = 1'b0;
    is_set  = 1'b0;
    is_sync = 1'b0;
    case (kind_e'(s1_kind_q))
      KindTick: is_tick = 1'b1;
      KindSet:  is_set  = 1'b1;
      KindSync: is_sync = 1'b1;
      default:  ;
    endcase
  end

  assign at_frame = is_tick && (step_q == '0);
  assign commit   = at_frame && pend_q;
  assign step_inc = {1'b0, step_q} + (StepW+1)'(1);
  assign step_d   = (step_inc >= {1'b0, OffLevel}) ? '0 : step_inc[StepW-1:0];

  always_comb begin
    for (int i = 0; i < LED_COUNT; i++) begin
      eff_level[i] = commit ? staged_q[i] : active_q[i];
    end
    pattern_d = '0;
    for (int i = 0; i < PatLeds; i++) begin
      pattern_d[i] = is_tick && (eff_level[i] < OffLevel) && (step_q >= eff_level[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        staged_q[i] <= OffLevel;
        active_q[i] <= OffLevel;
      end
      step_q <= '0;
      pend_q <= 1'b0;
    end else if (s1_adv) begin
      if (is_tick) begin
        step_q <= step_d;
      end
      if (commit) begin
        for (int i = 0; i < LED_COUNT; i++) begin
          active_q[i] <= staged_q[i];
        end
        pend_q <= 1'b0;
      end else if (is_sync) begin
        pend_q <= 1'b1;
      end
      if (is_set) begin
        for (int i = 0; i < LED_COUNT; i++) begin
          if (s1_all_q || (32'(s1_index_q) == i)) begin
            staged_q[i] <= s1_level_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pattern_q <= pattern_d;
      out_fstart_q  <= at_frame;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_pattern_q);
  assign m_axis_tuser_o  = out_fstart_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < OffLevel)
    else $error("step counter left the frame");

  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && at_frame) |=> !pend_q)
    else $error("commit left pending set");

  a_frame_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && at_frame) |=> (m_axis_tvalid_o && m_axis_tuser_o))
    else $error("frame start not reported");

  a_dark_non_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !is_tick) |=> (m_axis_tdata_o == '0 && !m_axis_tuser_o))
    else $error("non-tick request lit LEDs");

endmodule
